### design/fss_pkg.sv
// fss_pkg: shared types, constants and saturating adders for the flow shop
// schedule cost block; used by every module under flow_shop_schedule_cost
`default_nettype none
package fss_pkg;

  localparam int MAX_MACHINES = 8;
  localparam int POS_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [0:0] {
    CFG_MACHINES_IN_USE = 1'b0,
    CFG_DEPARTURE_START = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] duration;
    logic [15:0] inserted_delay;
    logic [31:0] earliest_start;
    logic [15:0] wait_cost_rate;
    logic [15:0] finished_cost_rate;
    logic        last_job;
  } task_in_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] wait_time;
    logic [15:0] wait_cost_rate;
    logic [15:0] finished_cost_rate;
    logic        mid_machine;
    logic        last_machine;
    logic        done;
  } timed_t;

  typedef struct packed {
    logic [31:0] task_start;
    logic [31:0] task_end;
    logic        batch_done;
    logic [47:0] wait_cost_total;
    logic [47:0] finished_cost_total;
    logic [31:0] delivery_time;
  } result_t;

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

endpackage
`default_nettype wire

### design/fss_timing.sv
// fss_timing: start and end time recurrence over machines and jobs, with the
// per-machine job-end store; depends on fss_pkg
`default_nettype none
module fss_timing import fss_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [3:0]    machines_in_use,
  input  wire logic          item_valid,
  input  wire task_in_t      item,
  output logic               item_ready,
  output logic               timed_valid,
  output timed_t             timed,
  input  wire logic          timed_ready
);

  logic [31:0]      previous_job_end [MAX_MACHINES];
  logic [31:0]      previous_machine_end;
  logic [POS_W-1:0] machine_position;
  logic             first_job_flag;

  logic [7:0]       last_wide;
  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] pos;
  logic             is_last;
  logic [31:0]      pj;
  logic [31:0]      base;
  logic [31:0]      start_time;
  logic [31:0]      end_time;
  logic [31:0]      wait_time;
  logic             done;
  logic             fire;

  assign item_ready = !timed_valid || timed_ready;
  assign fire = item_valid && item_ready;

  always_comb begin
    if (machines_in_use == 4'd0) begin
      last_wide = 8'd0;
    end else if (8'(machines_in_use) > 8'(MAX_MACHINES)) begin
      last_wide = 8'(MAX_MACHINES - 1);
    end else begin
      last_wide = 8'(machines_in_use) - 8'd1;
    end
    last_pos = last_wide[POS_W-1:0];
    pos = (machine_position > last_pos) ? last_pos : machine_position;
    is_last = (pos == last_pos);
    pj = previous_job_end[pos];
    if (first_job_flag) begin
      if (pos == '0) begin
        base = item.earliest_start;
      end else begin
        base = (item.earliest_start > previous_machine_end) ? item.earliest_start
                                                             : previous_machine_end;
      end
    end else if (pos == '0) begin
      base = pj;
    end else begin
      base = (pj > previous_machine_end) ? pj : previous_machine_end;
    end
    start_time = add_sat32(base, {16'd0, item.inserted_delay});
    end_time = add_sat32(start_time, {16'd0, item.duration});
    wait_time = (start_time >= previous_machine_end) ? start_time - previous_machine_end
                                                     : 32'd0;
    done = is_last && item.last_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_machine_end <= '0;
      machine_position <= '0;
      first_job_flag <= 1'b1;
      timed_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        timed_valid <= item_valid;
      end
      if (fire) begin
        if (done) begin
          previous_machine_end <= '0;
          machine_position <= '0;
          first_job_flag <= 1'b1;
        end else if (is_last) begin
          previous_machine_end <= end_time;
          machine_position <= '0;
          first_job_flag <= 1'b0;
        end else begin
          previous_machine_end <= end_time;
          machine_position <= pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      previous_job_end[pos] <= end_time;
      timed.start_time <= start_time;
      timed.end_time <= end_time;
      timed.wait_time <= wait_time;
      timed.wait_cost_rate <= item.wait_cost_rate;
      timed.finished_cost_rate <= item.finished_cost_rate;
      timed.mid_machine <= (pos != '0) && (pos < last_pos);
      timed.last_machine <= is_last;
      timed.done <= done;
    end
  end

endmodule
`default_nettype wire

### design/fss_cost.sv
// fss_cost: product, accumulate and finish stages for the wait cost, the
// finished-stock cost and the delivery time; depends on fss_pkg
`default_nettype none
module fss_cost import fss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] departure_window_start,
  input  wire logic        timed_valid,
  input  wire timed_t      timed,
  output logic             timed_ready,
  output logic             result_valid,
  output result_t          result,
  input  wire logic        result_stall
);

  // product stage
  logic        valid2;
  logic [31:0] start2;
  logic [31:0] end2;
  logic        done2;
  logic        mid2;
  logic        last2;
  logic [47:0] wait_product;
  logic [47:0] end_product;
  logic [31:0] rate_snapshot;

  // accumulate stage
  logic        valid3;
  logic [31:0] start3;
  logic [31:0] end3;
  logic        done3;
  logic [47:0] wait_total3;
  logic [63:0] weighted3;
  logic [63:0] product3;
  logic [31:0] delivery3;

  logic [31:0] finished_rate_sum;
  logic [47:0] wait_cost_sum;
  logic [63:0] weighted_end_sum;

  logic        ready2;
  logic        ready3;
  logic        ready_out;
  logic [31:0] rate_next;
  logic [47:0] wait_sum_next;
  logic [63:0] weighted_next;
  logic [63:0] finished_diff;
  logic [47:0] finished_sat;

  assign ready_out = !result_valid || !result_stall;
  assign ready3 = !valid3 || ready_out;
  assign ready2 = !valid2 || ready3;
  assign timed_ready = ready2;

  always_comb begin
    rate_next = timed.last_machine
              ? add_sat32(finished_rate_sum, {16'd0, timed.finished_cost_rate})
              : finished_rate_sum;
    wait_sum_next = mid2 ? add_sat48(wait_cost_sum, wait_product) : wait_cost_sum;
    weighted_next = last2 ? add_sat64(weighted_end_sum, {16'd0, end_product})
                          : weighted_end_sum;
    finished_diff = (product3 >= weighted3) ? product3 - weighted3 : 64'd0;
    finished_sat = (finished_diff[63:48] != 16'd0) ? MAX48 : finished_diff[47:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      result_valid <= 1'b0;
      finished_rate_sum <= '0;
      wait_cost_sum <= '0;
      weighted_end_sum <= '0;
    end else begin
      if (ready2) begin
        valid2 <= timed_valid;
      end
      if (ready3) begin
        valid3 <= valid2;
      end
      if (ready_out) begin
        result_valid <= valid3;
      end
      if (timed_valid && ready2) begin
        finished_rate_sum <= timed.done ? 32'd0 : rate_next;
      end
      if (valid2 && ready3) begin
        wait_cost_sum <= done2 ? 48'd0 : wait_sum_next;
        weighted_end_sum <= done2 ? 64'd0 : weighted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (timed_valid && ready2) begin
      start2 <= timed.start_time;
      end2 <= timed.end_time;
      done2 <= timed.done;
      mid2 <= timed.mid_machine;
      last2 <= timed.last_machine;
      wait_product <= 48'(timed.wait_time) * 48'(timed.wait_cost_rate);
      end_product <= 48'(timed.end_time) * 48'(timed.finished_cost_rate);
      rate_snapshot <= rate_next;
    end
    if (valid2 && ready3) begin
      start3 <= start2;
      end3 <= end2;
      done3 <= done2;
      wait_total3 <= wait_sum_next;
      weighted3 <= weighted_next;
      product3 <= 64'(end2) * 64'(rate_snapshot);
      delivery3 <= add_sat32(end2, departure_window_start);
    end
    if (valid3 && ready_out) begin
      result.task_start <= start3;
      result.task_end <= end3;
      result.batch_done <= done3;
      result.wait_cost_total <= done3 ? wait_total3 : 48'd0;
      result.finished_cost_total <= done3 ? finished_sat : 48'd0;
      result.delivery_time <= done3 ? delivery3 : 32'd0;
    end
  end

endmodule
`default_nettype wire

### design/flow_shop_schedule_cost.sv
// flow_shop_schedule_cost: top level with the input register, configuration
// registers and result ports; instantiates fss_timing and fss_cost, uses fss_pkg
//
// Tasks of a permutation flow shop enter in job-major order, one word per task,
// and each gives one result word with its start and end time; on the final task
// of the batch the wait cost, finished-stock cost and delivery time are also
// reported and the batch state clears. One task is taken every clock cycle
// unless the output stalls; each word passes through the input register, time
// recurrence, products, accumulation and result register. The one-task-per-cycle
// rate is set by the start/end time recurrence, computed combinationally from
// the previous task's end times. Write configuration only while the block is
// empty.
`default_nettype none
module flow_shop_schedule_cost import fss_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] duration,
  input  wire logic [15:0] inserted_delay,
  input  wire logic [31:0] earliest_start,
  input  wire logic [15:0] wait_cost_rate,
  input  wire logic [15:0] finished_cost_rate,
  input  wire logic        last_job,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      task_start,
  output logic [31:0]      task_end,
  output logic             batch_done,
  output logic [47:0]      wait_cost_total,
  output logic [47:0]      finished_cost_total,
  output logic [31:0]      delivery_time
);

  logic [3:0]  machines_in_use;
  logic [31:0] departure_window_start;

  logic        item_valid;
  task_in_t    item;
  logic        item_ready;
  logic        timed_valid;
  timed_t      timed;
  logic        timed_ready;
  result_t     result;

  assign in_stall = item_valid && !item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      machines_in_use <= 4'd8;
      departure_window_start <= '0;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_MACHINES_IN_USE: machines_in_use <= cfg_data[3:0];
        CFG_DEPARTURE_START: departure_window_start <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.duration <= duration;
      item.inserted_delay <= inserted_delay;
      item.earliest_start <= earliest_start;
      item.wait_cost_rate <= wait_cost_rate;
      item.finished_cost_rate <= finished_cost_rate;
      item.last_job <= last_job;
    end
  end

  fss_timing u_timing (
    .clk             (clk),
    .rst             (rst),
    .machines_in_use (machines_in_use),
    .item_valid      (item_valid),
    .item            (item),
    .item_ready      (item_ready),
    .timed_valid     (timed_valid),
    .timed           (timed),
    .timed_ready     (timed_ready)
  );

  fss_cost u_cost (
    .clk                    (clk),
    .rst                    (rst),
    .departure_window_start (departure_window_start),
    .timed_valid            (timed_valid),
    .timed                  (timed),
    .timed_ready            (timed_ready),
    .result_valid           (out_valid),
    .result                 (result),
    .result_stall           (out_stall)
  );

  assign task_start = result.task_start;
  assign task_end = result.task_end;
  assign batch_done = result.batch_done;
  assign wait_cost_total = result.wait_cost_total;
  assign finished_cost_total = result.finished_cost_total;
  assign delivery_time = result.delivery_time;

endmodule
`default_nettype wire
